/* rtl/core/bitmap_block_allocator_macros.svh */
// assertion macros used by the allocator controller
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BBA_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BBA_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

/* rtl/core/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants, codes and controller/datapath link types
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int WORD_BITS  = 32;
    localparam int MAX_WORDS  = 64;
    localparam int WIDX_W     = $clog2(MAX_WORDS);
    localparam int BIDX_W     = $clog2(WORD_BITS);
    localparam int NW_W       = 7;
    localparam int BS_W       = 21;
    localparam int IDX_W      = 11;
    localparam int DATA_W     = 32;
    localparam int DIV_CNT_W  = 5;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

    localparam logic [1:0] CFG_NUM_WORDS  = 2'd0;
    localparam logic [1:0] CFG_BLOCK_SIZE = 2'd1;
    localparam logic [1:0] CFG_HEAP_BASE  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       latch;
        logic       srch_init;
        logic       srch_step;
        logic       div_init;
        logic       div_step;
        logic       load_word;
        logic       modify;
        logic       mul;
        logic       add;
        logic       clear;
        logic       set_stat;
        logic [1:0] stat;
    } bba_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       size_bad;
        logic       in_range;
        logic       hit;
        logic       last;
        logic       div_done;
    } bba_stat_t;

endpackage

/* rtl/core/bitmap_block_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// fixed-size block allocator keeping a used-block bitmap in ram
// ----------------------------------------------------------------------------
// usage
//   request channel: drive cmd, request_size and address with start high; the
//   request is taken when start is high and busy is low. busy stays high until
//   the result has been shown.
//   result channel: done is high for exactly one cycle with status,
//   block_index, block_address, in_heap and all_free; the receiver cannot stall
//   it and must capture the result in that cycle.
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
//   ready, write only while idle.
//   sequence: clear, bad size, outside heap or unknown command go from decode
//   straight to the result; allocate scans words (one bitmap word flag per cycle)
//   and free divides (32 quotient bits, one per cycle from the serial divider),
//   then both read, modify and write the word, multiply, add and show the result.
//   one request at a time; the next may start the cycle after done.
//   reset: bitmap reads as all free through per-word valid flags, so no
//   clearing pass; search start at word 0, config registers back to their defaults.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                cmd,
    input  logic [31:0]               request_size,
    input  logic [31:0]               address,
    output logic                      done,
    output logic [1:0]                status,
    output logic [bba_pkg::IDX_W-1:0] block_index,
    output logic [31:0]               block_address,
    output logic                      in_heap,
    output logic                      all_free,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data
);
    import bba_pkg::*;

    bba_cmd_t  ctl;
    bba_stat_t sts;

    assign cfg_ready = 1'b1;

    // controller
    bba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .ctl   (ctl)
    );

    // datapath
    bba_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .cmd           (cmd),
        .request_size  (request_size),
        .address       (address),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .status        (status),
        .block_index   (block_index),
        .block_address (block_address),
        .in_heap       (in_heap),
        .all_free      (all_free)
    );

endmodule

/* rtl/core/bba_ram.sv */
// ----------------------------------------------------------------------------
// bba_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/bba_dp.sv */
// ----------------------------------------------------------------------------
// bba_dp
// datapath: config registers, bitmap ram with word flags, search pointer,
// serial divider and address arithmetic
// ----------------------------------------------------------------------------
module bba_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bba_pkg::bba_cmd_t            ctl,
    output bba_pkg::bba_stat_t           sts,
    input  logic [1:0]                   cmd,
    input  logic [31:0]                  request_size,
    input  logic [31:0]                  address,
    input  logic                         cfg_wr,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    output logic [1:0]                   status,
    output logic [bba_pkg::IDX_W-1:0]    block_index,
    output logic [31:0]                  block_address,
    output logic                         in_heap,
    output logic                         all_free
);
    import bba_pkg::*;

    logic [NW_W-1:0]      nw_raw_reg;
    logic [BS_W-1:0]      bs_raw_reg;
    logic [31:0]          base_reg;
    logic [1:0]           cmd_reg;
    logic [31:0]          req_reg;
    logic [31:0]          addr_reg;
    logic [WIDX_W-1:0]    start_reg;
    logic [WIDX_W-1:0]    cur_reg;
    logic [WIDX_W-1:0]    k_reg;
    logic [BS_W-1:0]      rem_reg;
    logic [31:0]          quo_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic                 ddone_reg;
    logic [WIDX_W-1:0]    word_reg;
    logic [1:0]           stat_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [31:0]          prod_reg;
    logic [31:0]          baddr_reg;
    logic [MAX_WORDS-1:0] valid_reg;
    logic [MAX_WORDS-1:0] nz_reg;
    logic [MAX_WORDS-1:0] full_reg;

    logic [NW_W-1:0]      nw;
    logic [BS_W-1:0]      bs;
    logic [32:0]          off;
    logic [32:0]          heap_bytes;
    logic [NW_W-1:0]      cur_inc;
    logic [NW_W-1:0]      start_inc;
    logic [WIDX_W-1:0]    s_eff;
    logic [BS_W:0]        trial;
    logic [BS_W:0]        trial_sub;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] new_word;
    logic [BIDX_W-1:0]    free_bit;
    logic [MAX_WORDS-1:0] live_mask;
    logic                 is_alloc;

    // effective configuration
    always_comb
    begin
        if (nw_raw_reg == '0)
            nw = NW_W'(1);
        else if (nw_raw_reg > NW_W'(MAX_WORDS))
            nw = NW_W'(MAX_WORDS);
        else
            nw = nw_raw_reg;
        bs = (bs_raw_reg == '0) ? BS_W'(1) : bs_raw_reg;
    end

    // heap range test
    assign heap_bytes = {(BS_W + NW_W)'(bs * nw), 5'b0};
    assign off        = {1'b0, addr_reg} - {1'b0, base_reg};
    assign in_heap    = !off[32] && ({1'b0, off[31:0]} < heap_bytes);

    // search pointer arithmetic
    assign s_eff     = ({1'b0, start_reg} < nw) ? start_reg : '0;
    assign start_inc = {1'b0, s_eff} + NW_W'(1);
    assign cur_inc   = {1'b0, cur_reg} + NW_W'(1);

    // restoring divider step
    assign trial     = {rem_reg, quo_reg[31]};
    assign trial_sub = trial - {1'b0, bs};

    // word read-modify
    assign is_alloc = (cmd_reg == CMD_ALLOC);
    assign cur_word = valid_reg[word_reg] ? rd_data : '0;

    always_comb
    begin
        free_bit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (!cur_word[j])
                free_bit = BIDX_W'(j);
        end
        if (is_alloc)
            new_word = cur_word | (WORD_BITS'(1) << free_bit);
        else
            new_word = cur_word & ~(WORD_BITS'(1) << idx_reg[BIDX_W-1:0]);
    end

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ctl.modify),
        .waddr (word_reg),
        .wdata (new_word),
        .raddr (word_reg),
        .rdata (rd_data)
    );

    // emptiness over live words
    always_comb
    begin
        for (int i = 0; i < MAX_WORDS; i++)
            live_mask[i] = (NW_W'(i) < nw);
    end
    assign all_free = ~|(nz_reg & live_mask);

    // status to controller
    assign sts.cmd      = cmd_reg;
    assign sts.size_bad = (req_reg == '0) || (req_reg > {11'b0, bs});
    assign sts.in_range = in_heap;
    assign sts.hit      = !full_reg[cur_reg];
    assign sts.last     = ({1'b0, k_reg} == (nw - NW_W'(1)));
    assign sts.div_done = ddone_reg;

    assign status        = stat_reg;
    assign block_index   = idx_reg;
    assign block_address = baddr_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nw_raw_reg <= NW_W'(64);
            bs_raw_reg <= BS_W'(64);
            base_reg   <= '0;
            start_reg  <= '0;
            valid_reg  <= '0;
            nz_reg     <= '0;
            full_reg   <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_NUM_WORDS:  nw_raw_reg <= cfg_data[NW_W-1:0];
                    CFG_BLOCK_SIZE: bs_raw_reg <= cfg_data[BS_W-1:0];
                    CFG_HEAP_BASE:  base_reg   <= cfg_data;
                    default:        ;
                endcase
            end
            if (ctl.srch_init)
                start_reg <= (start_inc == nw) ? '0 : start_inc[WIDX_W-1:0];
            if (ctl.clear)
            begin
                valid_reg <= '0;
                nz_reg    <= '0;
                full_reg  <= '0;
            end
            else if (ctl.modify)
            begin
                valid_reg[word_reg] <= 1'b1;
                nz_reg[word_reg]    <= (new_word != '0);
                full_reg[word_reg]  <= (new_word == '1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg   <= cmd;
            req_reg   <= request_size;
            addr_reg  <= address;
            stat_reg  <= ST_OK;
            idx_reg   <= '0;
            baddr_reg <= '0;
        end
        if (ctl.set_stat)
            stat_reg <= ctl.stat;
        if (ctl.srch_init)
        begin
            cur_reg <= s_eff;
            k_reg   <= '0;
        end
        else if (ctl.srch_step)
        begin
            cur_reg <= (cur_inc == nw) ? '0 : cur_inc[WIDX_W-1:0];
            k_reg   <= k_reg + WIDX_W'(1);
        end
        if (ctl.div_init)
        begin
            rem_reg   <= '0;
            quo_reg   <= off[31:0];
            dcnt_reg  <= '0;
            ddone_reg <= 1'b0;
        end
        else if (ctl.div_step)
        begin
            if (!trial_sub[BS_W])
            begin
                rem_reg <= trial_sub[BS_W-1:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[BS_W-1:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            dcnt_reg  <= dcnt_reg + DIV_CNT_W'(1);
            ddone_reg <= (dcnt_reg == '1);
        end
        if (ctl.load_word)
        begin
            if (is_alloc)
                word_reg <= cur_reg;
            else
            begin
                word_reg <= quo_reg[WIDX_W+BIDX_W-1:BIDX_W];
                idx_reg  <= quo_reg[IDX_W-1:0];
            end
        end
        if (ctl.modify && is_alloc)
            idx_reg <= {word_reg, free_bit};
        if (ctl.mul)
            prod_reg <= 32'(idx_reg * bs);
        if (ctl.add)
            baddr_reg <= base_reg + prod_reg;
    end

endmodule

/* rtl/core/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// bba_ctrl
// controller state machine sequencing search, division and map update
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_macros.svh"

module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  bba_pkg::bba_stat_t sts,
    output bba_pkg::bba_cmd_t  ctl
);
    import bba_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SEARCH = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_RDWAIT = 4'd4;
    localparam logic [3:0] S_MODIFY = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_ADD    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.cmd)
                    CMD_ALLOC:
                    begin
                        if (sts.size_bad)
                        begin
                            ctl.set_stat = 1'b1;
                            ctl.stat     = ST_BAD_SIZE;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            ctl.srch_init = 1'b1;
                            state_next    = S_SEARCH;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (!sts.in_range)
                        begin
                            ctl.set_stat = 1'b1;
                            ctl.stat     = ST_OUTSIDE;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            ctl.div_init = 1'b1;
                            state_next   = S_DIV;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        ctl.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (sts.hit)
                begin
                    ctl.load_word = 1'b1;
                    state_next    = S_RDWAIT;
                end
                else if (sts.last)
                begin
                    ctl.set_stat = 1'b1;
                    ctl.stat     = ST_NO_FREE;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctl.srch_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    ctl.load_word = 1'b1;
                    state_next    = S_RDWAIT;
                end
                else
                begin
                    ctl.div_step = 1'b1;
                end
            end
            S_RDWAIT: state_next = S_MODIFY;
            S_MODIFY:
            begin
                ctl.modify = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                ctl.add    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // checks
    `BBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not go busy")
    `BBA_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `BBA_ASSERT_NOW(a_done_busy, done, busy, "result strobe while idle")
    `BBA_ASSERT_NEXT(a_modify_once, ctl.modify, !ctl.modify, "map written twice in a row")

endmodule

/* test/allocator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocator_checker
// watches the request, result and register channels of the block allocator,
// keeps its own bitmap and settings, and compares every result field by field
// ----------------------------------------------------------------------------
module allocator_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [1:0]                cmd,
    input  logic [31:0]               request_size,
    input  logic [31:0]               address,
    input  logic                      done,
    input  logic [1:0]                status,
    input  logic [bba_pkg::IDX_W-1:0] block_index,
    input  logic [31:0]               block_address,
    input  logic                      in_heap,
    input  logic                      all_free,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data,
    output int                        fail_count,
    output int                        pending
);
    import bba_pkg::*;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] index;
        logic [31:0]      addr;
        logic             in_heap;
        logic             all_free;
    } outcome_t;

    logic [WORD_BITS-1:0] used_map [MAX_WORDS];
    int unsigned          start_word;
    logic [NW_W-1:0]      num_words;
    logic [BS_W-1:0]      block_size;
    logic [31:0]          heap_base;
    outcome_t             outcome_q [$];

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    // work out the outcome of one request and update the bitmap
    function automatic outcome_t allocate_or_free(input logic [1:0] c,
                                                  input logic [31:0] req,
                                                  input logic [31:0] adr);
        outcome_t        o;
        int unsigned     nw, s, w, blk;
        longint unsigned bs, heap_bytes;
        logic            found;
        o = '0;
        found = 0;
        nw = (num_words == 0) ? 1 : (num_words > MAX_WORDS ? MAX_WORDS : num_words);
        bs = (block_size == 0) ? 1 : block_size;
        heap_bytes = bs * nw * WORD_BITS;
        o.in_heap = (adr >= heap_base) && (longint'(adr) - heap_base < heap_bytes);
        if (c == CMD_ALLOC) begin
            if (req == 0 || req > bs)
                o.status = ST_BAD_SIZE;
            else begin
                s = (start_word < nw) ? start_word : 0;
                start_word = (s + 1) % nw;
                for (int k = 0; k < nw && !found; k++) begin
                    w = (s + k) % nw;
                    for (int j = 0; j < WORD_BITS && !found; j++)
                        if (!used_map[w][j]) begin
                            used_map[w][j] = 1'b1;
                            o.index = w * WORD_BITS + j;
                            o.addr = heap_base + (w * WORD_BITS + j) * bs;
                            found = 1;
                        end
                end
                if (!found)
                    o.status = ST_NO_FREE;
            end
        end
        else if (c == CMD_FREE) begin
            if (!o.in_heap)
                o.status = ST_OUTSIDE;
            else begin
                blk = (longint'(adr) - heap_base) / bs;
                if (blk / WORD_BITS < MAX_WORDS)
                    used_map[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
                o.index = blk;
                o.addr = heap_base + longint'(blk) * bs;
            end
        end
        else if (c == CMD_CLEAR) begin
            foreach (used_map[i])
                used_map[i] = '0;
        end
        o.all_free = 1;
        for (int i = 0; i < nw; i++)
            if (used_map[i] != 0)
                o.all_free = 0;
        return o;
    endfunction

    // follow the channels and compare
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n) begin
            foreach (used_map[i])
                used_map[i] = '0;
            start_word = 0;
            num_words = 7'd64;
            block_size = 21'd64;
            heap_base = '0;
            outcome_q.delete();
            pending = 0;
            fail_count = 0;
        end
        else begin
            if (done) begin
                if (outcome_q.size() == 0)
                    report("result with no request outstanding", 1, 0);
                else begin
                    want = outcome_q.pop_front();
                    if (status !== want.status)
                        report("status", status, want.status);
                    if (block_index !== want.index)
                        report("block_index", block_index, want.index);
                    if (block_address !== want.addr)
                        report("block_address", block_address, want.addr);
                    if (in_heap !== want.in_heap)
                        report("in_heap", in_heap, want.in_heap);
                    if (all_free !== want.all_free)
                        report("all_free", all_free, want.all_free);
                end
            end
            if (start && !busy)
                outcome_q.push_back(allocate_or_free(cmd, request_size, address));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NUM_WORDS:  num_words = cfg_data[NW_W-1:0];
                    CFG_BLOCK_SIZE: block_size = cfg_data[BS_W-1:0];
                    CFG_HEAP_BASE:  heap_base = cfg_data;
                    default: ;
                endcase
            end
            pending = outcome_q.size();
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives allocate, free, clear and unknown-command requests through several heap
// settings, with random gaps, and gives the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module testbench;
    import bba_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        cmd;
    logic [31:0]       request_size;
    logic [31:0]       address;
    logic              done;
    logic [1:0]        status;
    logic [IDX_W-1:0]  block_index;
    logic [31:0]       block_address;
    logic              in_heap;
    logic              all_free;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [31:0]       cfg_data;
    int                fail_count;
    int                pending;
    int                quiet_cycles;
    logic [31:0]       cur_base;
    logic [20:0]       cur_bsize;
    logic [6:0]        cur_words;
    logic              gaps_on;

    bitmap_block_allocator DUT (.*);

    allocator_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // watchdog on cycles with nothing accepted
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // wait for every result, then let the block settle
    task automatic drain;
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic configure(input logic [6:0] w, input logic [20:0] b, input logic [31:0] hb);
        drain();
        cur_words = w;
        cur_bsize = b;
        cur_base  = hb;
        write_reg(CFG_NUM_WORDS, {25'd0, w});
        write_reg(CFG_BLOCK_SIZE, {11'd0, b});
        write_reg(CFG_HEAP_BASE, hb);
    endtask

    task automatic send(input logic [1:0] c, input logic [31:0] req, input logic [31:0] adr);
        while (gaps_on && $urandom_range(99) < 11)
            @(posedge clk);
        start        <= 1;
        cmd          <= c;
        request_size <= req;
        address      <= adr;
        do @(posedge clk); while (busy);
        start <= 0;
        // block is busy for the next cycles anyway
        @(posedge clk);
    endtask

    // mostly well-formed traffic: allocations and frees of heap addresses
    task automatic random_phase(input int n);
        logic [31:0] eb;
        logic [31:0] blocks;
        int          r;
        eb = (cur_bsize == 0) ? 1 : cur_bsize;
        blocks = ((cur_words == 0) ? 1 : (cur_words > 64 ? 64 : cur_words)) * 32;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 50)
                send(CMD_ALLOC, $urandom_range(eb, 1), $urandom());
            else if (r < 85)
                send(CMD_FREE, $urandom(),
                     cur_base + $urandom_range(blocks - 1) * eb + $urandom_range(eb - 1));
            else if (r < 88)
                send(CMD_CLEAR, $urandom(), $urandom());
            else if (r < 90)
                send(CMD_NONE, $urandom(), $urandom());
            else if (r < 95)
                send(CMD_ALLOC, (r[0] ? 32'd0 : eb + $urandom_range(1000)), $urandom());
            else
                send(CMD_FREE, $urandom(), $urandom());
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        cmd = CMD_ALLOC;
        request_size = 0;
        address = 0;
        cfg_valid = 0;
        cfg_index = CFG_NUM_WORDS;
        cfg_data = 0;
        gaps_on = 0;
        cur_words = 64;
        cur_bsize = 64;
        cur_base = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes and each special case at reset settings
        send(CMD_ALLOC, 32'd1, 32'd0);
        send(CMD_ALLOC, 32'd64, 32'hFFFF_FFFF);
        send(CMD_ALLOC, 32'd0, 32'd0);
        send(CMD_ALLOC, 32'd65, 32'd0);
        send(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send(CMD_FREE, 32'd0, 32'd0);
        send(CMD_FREE, 32'd0, 32'd0);
        send(CMD_FREE, 32'hFFFF_FFFF, 32'd131071);
        send(CMD_FREE, 32'd0, 32'd131072);
        send(CMD_FREE, 32'd0, 32'hFFFF_FFFF);
        send(CMD_NONE, 32'hFFFF_FFFF, 32'hAAAA_5555);
        send(CMD_CLEAR, 32'h5555_AAAA, 32'd100);
        // single word: fill it, then hit the full heap
        configure(7'd1, 21'd1, 32'hFFFF_FFF0);
        for (int i = 0; i < 33; i++)
            send(CMD_ALLOC, 32'd1, 32'hFFFF_FFF0 + i);
        send(CMD_FREE, 32'd0, 32'hFFFF_FFEF);
        send(CMD_FREE, 32'd0, 32'h0000_000F);
        // out-of-range settings, blocks beyond the word count keep bits
        configure(7'd0, 21'd0, 32'd0);
        send(CMD_ALLOC, 32'd1, 32'd0);
        configure(7'd127, 21'h1FFFFF, 32'h8000_0000);
        send(CMD_ALLOC, 32'h1FFFFF, 32'h8000_0000);
        send(CMD_FREE, 32'd0, 32'hFFFF_FFFF);

        // random phases over several settings, the extremes among them
        configure(7'd2, 21'd4, 32'h1000);
        random_phase(400);
        gaps_on = 1;
        random_phase(300);
        // hold off until the block has returned everything
        drain();
        configure(7'd64, 21'd1048576, 32'h0001_0000);
        random_phase(300);
        configure(7'd3, 21'd1, 32'hFFFF_FF00);
        random_phase(400);
        configure(7'd5, 21'd13, $urandom());
        random_phase(300);
        configure(7'd1, 21'd64, 32'd0);
        random_phase(200);

        drain();
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
